/* sv/dynamic_priority_scheduler_core_defines.svh */
// assertion macros for the dynamic priority scheduler
// used at the end of the top level, expects clk and rst in scope
`ifndef DYNAMIC_PRIORITY_SCHEDULER_CORE_DEFINES_SVH
`define DYNAMIC_PRIORITY_SCHEDULER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DPS_ASSERT_IMP(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DPS_ASSERT_NXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

/* sv/dps_pkg.sv */
// shared types and constants for the dynamic priority scheduler
// no dependencies
package dps_pkg;

  localparam int SLOTS   = 16;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int SLOT_FW = 4;
  localparam int REQ_W   = 4;
  localparam int NEED_W  = 4;
  localparam int RC_W    = 4;
  localparam int PRIO_W  = 5;

  typedef logic signed [PRIO_W-1:0] prio_t;

  localparam prio_t PRIO_MIN = 5'sb10000;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // candidate handed along the cell chain
  typedef struct packed {
    logic              vld;
    logic [IDX_W-1:0]  idx;
    prio_t             prio;
    logic [RC_W-1:0]   rc;
    logic [NEED_W-1:0] need;
  } cand_t;

  // load broadcast to all cells
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    prio_t             prio;
    logic [NEED_W-1:0] need;
  } load_t;

  // winner update broadcast to all cells
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    prio_t            prio;
    logic [RC_W-1:0]  rc;
    logic             fin;
  } upd_t;

endpackage

/* sv/dps_cell.sv */
// one process table entry plus one stage of the max-priority chain
// depends on dps_pkg
module dps_cell import dps_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] cell_idx,
  input  load_t            load,
  input  upd_t             upd,
  input  cand_t            cand_in,
  output cand_t            cand_out
);

  logic              valid;
  prio_t             prio;
  logic [NEED_W-1:0] need;
  logic [RC_W-1:0]   rc;
  logic              load_hit;
  logic              upd_hit;
  logic              take_own;

  assign load_hit = load.en && (load.idx == cell_idx);
  assign upd_hit  = upd.en && (upd.idx == cell_idx);

  // entry valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load_hit) begin
      valid <= 1'b1;
    end else if (upd_hit && upd.fin) begin
      valid <= 1'b0;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (load_hit) begin
      prio <= load.prio;
      need <= load.need;
      rc   <= '0;
    end else if (upd_hit) begin
      prio <= upd.prio;
      rc   <= upd.rc;
    end
  end

  // own entry beats the incoming one only on strictly higher priority
  assign take_own = valid && (!cand_in.vld || ($signed(prio) > $signed(cand_in.prio)));

  // chain stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_out.vld <= 1'b0;
    end else begin
      cand_out.vld <= take_own || cand_in.vld;
    end
    if (take_own) begin
      cand_out.idx  <= cell_idx;
      cand_out.prio <= prio;
      cand_out.rc   <= rc;
      cand_out.need <= need;
    end else begin
      cand_out.idx  <= cand_in.idx;
      cand_out.prio <= cand_in.prio;
      cand_out.rc   <= cand_in.rc;
      cand_out.need <= cand_in.need;
    end
  end

endmodule

/* sv/dynamic_priority_scheduler_core.sv */
// tick: the result word is registered into the output word when the scan ends; no new item is taken
// until the sequencer is back in idle, and the scan end waits while the output is stalled
// load: taken while the sequencer is idle, back to back, no result; loads wait while a tick scans
// the scan time is set by the chain of SLOTS cells, one cell per cycle, plus the output register
// reset clears the entry valid bits, the sequencer and the output word valid
// depends on dps_pkg, dps_cell and dynamic_priority_scheduler_core_defines.svh
`include "dynamic_priority_scheduler_core_defines.svh"

module dynamic_priority_scheduler_core import dps_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     kind,
  input  logic [SLOT_FW-1:0]       slot,
  input  logic [REQ_W-1:0]         priority_req,
  input  logic [NEED_W-1:0]        need_time,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     idle,
  output logic [SLOT_FW-1:0]       ran_slot,
  output logic signed [PRIO_W-1:0] priority_after,
  output logic [RC_W-1:0]          run_count_after,
  output logic                     finished
);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             in_acc;
  logic             scan_done;
  load_t            load;
  upd_t             upd;
  cand_t            link [SLOTS+1];
  cand_t            best;
  prio_t            prio_new;
  logic [RC_W-1:0]  rc_new;
  logic             fin_new;

  assign in_acc = in_valid && !in_stall;

  // load broadcast, slots beyond the table are dropped
  always_comb begin
    load.en   = in_acc && (kind == KIND_LOAD) && (int'(slot) < SLOTS);
    load.idx  = IDX_W'(slot);
    load.prio = prio_t'({1'b0, priority_req});
    load.need = need_time;
  end

  // cell chain, candidate enters empty at the low end
  assign link[0] = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    dps_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (IDX_W'(i)),
      .load     (load),
      .upd      (upd),
      .cand_in  (link[i]),
      .cand_out (link[i+1])
    );
  end

  assign best = link[SLOTS];

  // winner decay and run count
  always_comb begin
    rc_new   = best.rc + RC_W'(1);
    prio_new = (best.prio == PRIO_MIN) ? best.prio : prio_t'(best.prio - PRIO_W'(1));
    fin_new  = (rc_new >= best.need);
  end

  always_comb begin
    upd.en   = scan_done && best.vld;
    upd.idx  = best.idx;
    upd.prio = prio_new;
    upd.rc   = rc_new;
    upd.fin  = fin_new;
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // next state, scan counter and handshake
  always_comb begin
    in_stall   = (state != ST_IDLE);
    scan_done  = (state == ST_SCAN) && (cnt == CNT_W'(SLOTS)) && (!out_valid || !out_stall);
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (in_acc && (kind == KIND_TICK)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt != CNT_W'(SLOTS)) begin
          cnt_next = cnt + CNT_W'(1);
        end
        if (scan_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (scan_done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output word payload, run fields zero and idle set when the table was empty
  always_ff @(posedge clk) begin
    if (scan_done) begin
      idle            <= !best.vld;
      ran_slot        <= best.vld ? SLOT_FW'(best.idx) : '0;
      priority_after  <= best.vld ? prio_new : '0;
      run_count_after <= best.vld ? rc_new : '0;
      finished        <= best.vld && fin_new;
    end
  end

  // checks
  `DPS_ASSERT_IMP(a_idle_word_empty, out_valid && idle, (ran_slot == '0) && !finished && (run_count_after == '0), "idle word carries run data")
  `DPS_ASSERT_IMP(a_prio_decayed, out_valid && !idle, priority_after != prio_t'(5'sd15), "priority not decayed")
  `DPS_ASSERT_NXT(a_tick_blocks, in_valid && !in_stall && (kind == KIND_TICK), in_stall, "tick did not start a scan")
  `DPS_ASSERT_IMP(a_word_from_scan, $rose(out_valid), $past(state == ST_SCAN), "word appeared without a scan")

endmodule
